// ----- src/bfa_pkg.sv -----
// Package: BN254 scalar field constants, opcodes and shared types.
package bfa_pkg;

  localparam int unsigned W = 256;

  localparam logic [W-1:0] P =
    256'd21888242871839275222246405745257275088548364400416034343698204186575808495617;
  localparam logic [W-1:0] P2 =
    256'd43776485743678550444492811490514550177096728800832068687396408373151616991234;
  localparam logic [W-1:0] P4 =
    256'd87552971487357100888985622981029100354193457601664137374792816746303233982468;
  localparam logic [W-1:0] P3 = P2 + P;
  localparam logic [W-1:0] P5 = P4 + P;
  localparam logic [W-1:0] MONT_J =
    256'd67081653635985823054489041608655630077888474459951605639066367465391537520641;
  localparam logic [W-1:0] BARR_F =
    256'd38284845454613504619394467267190322316714506535725634610690744705837986343205;

  localparam int unsigned BARR_SHIFT = 508;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_BMUL = 3'd2;
  localparam logic [2:0] OP_MMUL = 3'd3;
  localparam logic [2:0] OP_NEG  = 3'd4;
  localparam logic [2:0] OP_RED  = 3'd5;

  // decoded operation, all zero for unused opcodes
  typedef struct packed {
    logic add;
    logic sub;
    logic bmul;
    logic mmul;
    logic neg;
    logic red;
  } sel_t;

  typedef struct packed {
    sel_t         sel;
    logic [W-1:0] x;
    logic [W-1:0] y;
  } item_t;

  typedef struct packed {
    logic  vld;
    item_t item;
  } head_t;

endpackage

// ----- src/bfa_if.sv -----
// Channel interfaces: operand beats in, result beats out.
interface bfa_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [63:0] x_w0;
  logic [63:0] x_w1;
  logic [63:0] x_w2;
  logic [63:0] x_w3;
  logic [63:0] y_w0;
  logic [63:0] y_w1;
  logic [63:0] y_w2;
  logic [63:0] y_w3;
  modport source (output valid, opcode, x_w0, x_w1, x_w2, x_w3, y_w0, y_w1, y_w2, y_w3,
                  input ready);
  modport sink (input valid, opcode, x_w0, x_w1, x_w2, x_w3, y_w0, y_w1, y_w2, y_w3,
                output ready);
endinterface

interface bfa_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] r_w0;
  logic [63:0] r_w1;
  logic [63:0] r_w2;
  logic [63:0] r_w3;
  modport source (output valid, r_w0, r_w1, r_w2, r_w3, input ready);
  modport sink (input valid, r_w0, r_w1, r_w2, r_w3, output ready);
endinterface

// ----- src/bfa_front.sv -----
// Front end: accept operand beats, decode the opcode, hold them in a two-entry queue.
module bfa_front import bfa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bfa_in_if.sink      in_i,
  input  logic        pop_i,
  output head_t       head_o
);

  item_t       mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push;
  item_t       dec;

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;

  always_comb begin
    dec.sel.add  = (in_i.opcode == OP_ADD);
    dec.sel.sub  = (in_i.opcode == OP_SUB);
    dec.sel.bmul = (in_i.opcode == OP_BMUL);
    dec.sel.mmul = (in_i.opcode == OP_MMUL);
    dec.sel.neg  = (in_i.opcode == OP_NEG);
    dec.sel.red  = (in_i.opcode == OP_RED);
    dec.x = {in_i.x_w3, in_i.x_w2, in_i.x_w1, in_i.x_w0};
    dec.y = {in_i.y_w3, in_i.y_w2, in_i.y_w1, in_i.y_w0};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  assign head_o.vld  = (cnt_q != 2'd0);
  assign head_o.item = mem_q[rp_q];

endmodule

// ----- src/bfa_mul.sv -----
// Pipelined 512 x 256 multiplier built from 32 x 32 partial products, five stages.
module bfa_mul (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [511:0] a_i,
  input  logic [255:0] b_i,
  output logic [767:0] p_o
);

  logic [63:0]  pp_q  [16][8];
  logic [767:0] row_d [8];
  logic [767:0] row_q [8];
  logic [767:0] s3_q  [4];
  logic [767:0] s4_q  [2];
  logic [767:0] p_q;

  // even partial products of one row never overlap each other, nor do odd ones, so one add merges the two
  always_comb begin
    logic [767:0] ev;
    logic [767:0] od;
    for (int j = 0; j < 8; j++) begin
      ev = '0;
      od = '0;
      for (int i = 0; i < 16; i += 2) begin
        ev[32*i +: 64]      = pp_q[i][j];
        od[32*(i+1) +: 64]  = pp_q[i+1][j];
      end
      row_d[j] = (ev + od) << (32 * j);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 16; i++) begin
        for (int j = 0; j < 8; j++) begin
          pp_q[i][j] <= 64'(a_i[32*i +: 32]) * 64'(b_i[32*j +: 32]);
        end
      end
      for (int j = 0; j < 8; j++) row_q[j] <= row_d[j];
      for (int k = 0; k < 4; k++) s3_q[k] <= row_q[2*k] + row_q[2*k+1];
      for (int k = 0; k < 2; k++) s4_q[k] <= s3_q[2*k] + s3_q[2*k+1];
      p_q <= s4_q[0] + s4_q[1];
    end
  end

  assign p_o = p_q;

endmodule

// ----- src/bfa_back.sv -----
// Back end: three chained multipliers, final reduction and the output register.
module bfa_back import bfa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  head_t     head_i,
  output logic      pop_o,
  bfa_out_if.source out_o
);

  localparam int unsigned NS = 15;

  logic          en;
  logic          vld_q  [NS];
  item_t         line_q [NS];
  logic [511:0]  z_q    [5:NS-1];
  logic [767:0]  p1, p2, p3;
  logic [511:0]  a2, a3;
  logic [255:0]  b2;
  logic          oval_q;
  logic [W-1:0]  r_q, r_d;

  assign en    = !oval_q || out_o.ready;
  assign pop_o = en && head_i.vld;

  // first: z = x*y
  bfa_mul u_mul1 (.clk_i, .en_i(en), .a_i({256'b0, head_i.item.x}), .b_i(head_i.item.y),
                  .p_o(p1));

  // second: Barrett z*factor, or Montgomery (z mod R)*J
  assign a2 = line_q[4].sel.mmul ? {256'b0, p1[255:0]} : p1[511:0];
  assign b2 = line_q[4].sel.mmul ? MONT_J : BARR_F;
  bfa_mul u_mul2 (.clk_i, .en_i(en), .a_i(a2), .b_i(b2), .p_o(p2));

  // third: q*p
  assign a3 = line_q[9].sel.mmul ? {256'b0, p2[255:0]}
                                 : {252'b0, p2[767:BARR_SHIFT]};
  bfa_mul u_mul3 (.clk_i, .en_i(en), .a_i(a3), .b_i(P), .p_o(p3));

  always_ff @(posedge clk_i) begin
    if (en) begin
      line_q[0] <= head_i.item;
      for (int k = 1; k < NS; k++) line_q[k] <= line_q[k-1];
      z_q[5] <= p1[511:0];
      for (int k = 6; k < NS; k++) z_q[k] <= z_q[k-1];
      r_q <= r_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) vld_q[k] <= 1'b0;
      oval_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= head_i.vld;
      for (int k = 1; k < NS; k++) vld_q[k] <= vld_q[k-1];
      oval_q <= vld_q[NS-1];
    end
  end

  always_comb begin
    logic [W:0]     s;
    logic [W:0]     d;
    logic [319:0]   b5;
    logic [W:0]     m;
    logic [W-1:0]   rd;
    logic [W-1:0]   x, y;
    logic [511:0]   z;
    x = line_q[NS-1].x;
    y = line_q[NS-1].y;
    z = z_q[NS-1];

    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, P}) s = s - {1'b0, P};

    d = {1'b0, x} - {1'b0, y};
    if (d[W]) d = {1'b0, d[W-1:0] + P};

    b5 = z[319:0] - p3[319:0];
    if (b5 >= 320'(P)) b5 = b5 - 320'(P);

    m = {1'b0, z[511:256]} - {1'b0, p3[511:256]};
    if (m[W]) m = {1'b0, m[W-1:0] + P};

    // fold any 256-bit value below p; every compare looks at x directly
    if (x >= P5)      rd = x - P5;
    else if (x >= P4) rd = x - P4;
    else if (x >= P3) rd = x - P3;
    else if (x >= P2) rd = x - P2;
    else if (x >= P)  rd = x - P;
    else              rd = x;

    r_d = '0;
    if (line_q[NS-1].sel.add)  r_d = s[W-1:0];
    if (line_q[NS-1].sel.sub)  r_d = d[W-1:0];
    if (line_q[NS-1].sel.bmul) r_d = b5[W-1:0];
    if (line_q[NS-1].sel.mmul) r_d = m[W-1:0];
    if (line_q[NS-1].sel.neg)  r_d = (x != '0) ? P - x : '0;
    if (line_q[NS-1].sel.red)  r_d = rd;
  end

  assign out_o.valid = oval_q;
  assign out_o.r_w0  = r_q[63:0];
  assign out_o.r_w1  = r_q[127:64];
  assign out_o.r_w2  = r_q[191:128];
  assign out_o.r_w3  = r_q[255:192];

endmodule

// ----- src/bn254_field_alu.sv -----
// Top level: BN254 scalar field arithmetic unit.
//
//  channel | dir | beat contents
//  in_i    | in  | opcode, x_w0..x_w3, y_w0..y_w3
//  out_o   | out | r_w0..r_w3
//
// One beat per cycle in and out while out_o is not stalled; the latency from acceptance to result valid
// is set by three chained five-stage multipliers plus the output register.
// Reset clears the queue and pipeline valid bits only.
// A stalled output freezes the whole back pipeline; the two-entry queue absorbs
// input beats until it fills, then in_i.ready drops.
module bn254_field_alu import bfa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bfa_in_if.sink    in_i,
  bfa_out_if.source out_o
);

  head_t hd;
  logic  pop;

  bfa_front u_front (.clk_i, .rst_ni, .in_i, .pop_i(pop), .head_o(hd));
  bfa_back  u_back  (.clk_i, .rst_ni, .head_i(hd), .pop_o(pop), .out_o);

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> hd.vld)
    else $error("pop from empty queue");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !pop)
    else $error("queue popped while output stalled");

  a_full_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> hd.vld)
    else $error("queue full but head invalid");

endmodule
